FILE: design/tag_aware_text_line_scanner_defines.svh
// Assertion macros shared by the text line scanner modules.
// Needs clk and rst_n in the scope of each use.
`ifndef TAG_AWARE_TEXT_LINE_SCANNER_DEFINES_SVH
`define TAG_AWARE_TEXT_LINE_SCANNER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TALS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TALS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TALS_ASSERT_SAME(lbl, ante, cons)
`define TALS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/tals_pkg.sv
// Shared types and constants for the tag-aware text line scanner.
// No dependencies.
package tals_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int TAG_HEAD = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_END_CODE   = 2'd0,
        CFG_BREAK_CODE = 2'd1,
        CFG_TAG_CODE   = 2'd2,
        CFG_LEN_LIMIT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] end_code;
        logic [CFG_W-1:0] line_break_code;
        logic [CFG_W-1:0] tag_open_code;
        logic [CFG_W-1:0] length_limit;
    } cfg_t;

    typedef struct packed {
        logic             first;
        logic [CNT_W-1:0] line_index;
        logic             add_len;
        logic [CNT_W-1:0] len_amt;
        logic             brk;
        logic             line_unit;
        logic             last;
    } op_t;

endpackage

FILE: design/tals_in_if.sv
// Input channel of the text line scanner: one code unit per item.
// Depends on tals_pkg.
interface tals_in_if #(
    parameter int CODE_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [CODE_WIDTH-1:0]        code_unit;
    logic [tals_pkg::CNT_W-1:0]   line_index;

    modport source (output valid, output code_unit, output line_index, input ready);
    modport sink   (input valid, input code_unit, input line_index, output ready);
endinterface

FILE: design/tals_out_if.sv
// Result channel of the text line scanner: one item per string.
// Depends on tals_pkg.
interface tals_out_if;
    logic                         valid;
    logic                         ready;
    logic [tals_pkg::CNT_W-1:0]   line_count;
    logic [tals_pkg::CNT_W-1:0]   total_length;
    logic [tals_pkg::CNT_W-1:0]   line_length;
    logic                         line_found;
    logic                         too_long;

    modport source (output valid, output line_count, output total_length,
                    output line_length, output line_found, output too_long,
                    input ready);
    modport sink   (input valid, input line_count, input total_length,
                    input line_length, input line_found, input too_long,
                    output ready);
endinterface

FILE: design/tals_front.sv
// Front end: tracks tag phase and turns each code unit into a counter op.
// Depends on tals_pkg, tals_in_if and the assertion macro header.
`include "tag_aware_text_line_scanner_defines.svh"

module tals_front #(
    parameter int CODE_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    tals_in_if.sink         text,
    input  tals_pkg::cfg_t  cfg,
    output logic            op_valid,
    input  logic            op_ready,
    output tals_pkg::op_t   op
);

    localparam int AMT_W = (CODE_WIDTH + 1 > tals_pkg::CNT_W + 1) ?
                           CODE_WIDTH + 1 : tals_pkg::CNT_W + 1;

    typedef enum logic [1:0] {
        PH_START,
        PH_TEXT,
        PH_COUNT,
        PH_DATA
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CODE_WIDTH-1:0] tag_left_reg;
    logic [CODE_WIDTH-1:0] tag_left_next;
    logic [CODE_WIDTH-1:0] code;
    logic                  is_end;
    logic                  is_brk;
    logic                  is_tag;
    logic [AMT_W-1:0]      amt_wide;
    logic [tals_pkg::CNT_W-1:0] amt_sat;
    logic                  acc;

    assign code     = text.code_unit;
    assign is_end   = code == CODE_WIDTH'(cfg.end_code);
    assign is_brk   = code == CODE_WIDTH'(cfg.line_break_code);
    assign is_tag   = code == CODE_WIDTH'(cfg.tag_open_code);
    assign amt_wide = AMT_W'(code) + AMT_W'(tals_pkg::TAG_HEAD);
    assign amt_sat  = (amt_wide > AMT_W'(tals_pkg::CNT_MAX)) ?
                      tals_pkg::CNT_MAX : amt_wide[tals_pkg::CNT_W-1:0];

    assign op_valid   = text.valid;
    assign text.ready = op_ready;
    assign acc        = text.valid && op_ready;

    always_comb
    begin
        op            = '0;
        op.line_index = text.line_index;
        phase_next    = phase_reg;
        tag_left_next = tag_left_reg;
        unique case (phase_reg)
            PH_COUNT:
            begin
                op.add_len    = 1'b1;
                op.len_amt    = amt_sat;
                op.line_unit  = 1'b1;
                tag_left_next = code;
                phase_next    = (code != '0) ? PH_DATA : PH_TEXT;
            end
            PH_DATA:
            begin
                op.line_unit  = 1'b1;
                tag_left_next = tag_left_reg - CODE_WIDTH'(1);
                if (tag_left_reg == CODE_WIDTH'(1))
                begin
                    phase_next = PH_TEXT;
                end
            end
            PH_START, PH_TEXT:
            begin
                op.first = (phase_reg == PH_START);
                if (is_end)
                begin
                    op.last    = 1'b1;
                    phase_next = PH_START;
                end
                else
                begin
                    if (is_tag)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        op.add_len = 1'b1;
                        op.len_amt = tals_pkg::CNT_W'(1);
                        phase_next = PH_TEXT;
                    end
                    op.brk       = is_brk;
                    op.line_unit = !is_brk;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            tag_left_reg <= '0;
        end
        else if (acc)
        begin
            phase_reg    <= phase_next;
            tag_left_reg <= tag_left_next;
        end
    end

    `TALS_ASSERT_SAME(a_data_has_units, phase_reg == PH_DATA, tag_left_reg != '0)
    `TALS_ASSERT_NEXT(a_end_restarts, acc && op.last, phase_reg == PH_START)
    `TALS_ASSERT_NEXT(a_count_loads, acc && phase_reg == PH_COUNT,
                      tag_left_reg == $past(code))

endmodule

FILE: design/tals_fifo.sv
// Short op queue between the front and back ends.
// Depends on tals_pkg and the assertion macro header.
`include "tag_aware_text_line_scanner_defines.svh"

module tals_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tals_pkg::op_t push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tals_pkg::op_t pop_op
);

    localparam int DEPTH = tals_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tals_pkg::op_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    `TALS_ASSERT_NEXT(a_fill, push && !pop, count_reg == $past(count_reg) + CNT_W'(1))
    `TALS_ASSERT_NEXT(a_drain, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))
    `TALS_ASSERT_NEXT(a_head_holds, pop_valid && !pop, $stable(pop_op))

endmodule

FILE: design/tals_back.sv
// Back end: applies ops to the line and length counters, registers results.
// Depends on tals_pkg, tals_out_if and the assertion macro header.
`include "tag_aware_text_line_scanner_defines.svh"

module tals_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  tals_pkg::op_t  op,
    input  tals_pkg::cfg_t cfg,
    tals_out_if.source     result
);

    localparam int W = tals_pkg::CNT_W;

    logic [W-1:0] brk_reg,    brk_next,    brk_base;
    logic [W-1:0] len_reg,    len_next,    len_base;
    logic         lim_reg,    lim_next,    lim_base;
    logic [W-1:0] wanted_reg, wanted_next;
    logic [W-1:0] wll_reg,    wll_next,    wll_base;
    logic [W:0]   len_sum;
    logic [W-1:0] len_sat;
    logic         found;
    logic         pop;

    logic         out_valid_reg;
    logic [W-1:0] line_count_reg;
    logic [W-1:0] total_length_reg;
    logic [W-1:0] line_length_reg;
    logic         line_found_reg;
    logic         too_long_reg;

    assign op_ready = !(op.last && out_valid_reg && !result.ready);
    assign pop      = op_valid && op_ready;

    assign brk_base    = op.first ? '0 : brk_reg;
    assign len_base    = op.first ? '0 : len_reg;
    assign lim_base    = op.first ? 1'b0 : lim_reg;
    assign wll_base    = op.first ? '0 : wll_reg;
    assign wanted_next = op.first ? op.line_index : wanted_reg;

    assign len_sum = {1'b0, len_base} + {1'b0, op.len_amt};
    assign len_sat = len_sum[W] ? tals_pkg::CNT_MAX : len_sum[W-1:0];
    assign found   = wanted_next <= brk_base;

    always_comb
    begin
        len_next = len_base;
        lim_next = lim_base;
        brk_next = brk_base;
        wll_next = wll_base;
        if (op.add_len && !lim_base)
        begin
            len_next = len_sat;
            lim_next = len_sat >= cfg.length_limit;
        end
        if (op.brk && brk_base != tals_pkg::CNT_MAX)
        begin
            brk_next = brk_base + W'(1);
        end
        if (op.line_unit && brk_base == wanted_next && wll_base != tals_pkg::CNT_MAX)
        begin
            wll_next = wll_base + W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brk_reg       <= '0;
            len_reg       <= '0;
            lim_reg       <= 1'b0;
            wanted_reg    <= '0;
            wll_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && op.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                brk_reg    <= brk_next;
                len_reg    <= len_next;
                lim_reg    <= lim_next;
                wanted_reg <= wanted_next;
                wll_reg    <= wll_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && op.last)
        begin
            line_count_reg   <= (brk_base == tals_pkg::CNT_MAX) ?
                                tals_pkg::CNT_MAX : brk_base + W'(1);
            total_length_reg <= len_base;
            line_length_reg  <= found ? wll_base : '0;
            line_found_reg   <= found;
            too_long_reg     <= lim_base;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.line_count   = line_count_reg;
    assign result.total_length = total_length_reg;
    assign result.line_length  = line_length_reg;
    assign result.line_found   = line_found_reg;
    assign result.too_long     = too_long_reg;

    `TALS_ASSERT_NEXT(a_result_raised, pop && op.last, out_valid_reg)
    `TALS_ASSERT_NEXT(a_limit_sticks, lim_reg && !(pop && op.first), lim_reg)
    `TALS_ASSERT_SAME(a_absent_line_zero, out_valid_reg && !line_found_reg,
                      line_length_reg == '0)

endmodule

FILE: design/tag_aware_text_line_scanner.sv
// Sustains one code unit per cycle. The result for an end code is registered:
// its op passes through the two-entry op queue and the back end registers the
// result as it applies the op. Input stalls only while a result is held by the
// receiver and a later end code has reached the back end, which then waits and
// lets the queue fill. Tags (start code, count, data) are consumed whole by the
// front end, so their units never act as breaks or end codes. Configuration
// writes take effect at once and are meant for idle periods between strings.
// Depends on tals_pkg, tals_in_if, tals_out_if, tals_front, tals_fifo, tals_back.
module tag_aware_text_line_scanner #(
    parameter int CODE_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tals_in_if.sink                         text,
    tals_out_if.source                      result,
    input  logic                            cfg_wr_en,
    input  logic [tals_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tals_pkg::CFG_W-1:0]      cfg_data
);

    tals_pkg::cfg_t cfg_reg;
    tals_pkg::op_t  front_op;
    tals_pkg::op_t  queue_op;
    logic           front_valid;
    logic           front_ready;
    logic           queue_valid;
    logic           queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_code        <= tals_pkg::CFG_W'(0);
            cfg_reg.line_break_code <= tals_pkg::CFG_W'(10);
            cfg_reg.tag_open_code   <= tals_pkg::CFG_W'(61440);
            cfg_reg.length_limit    <= tals_pkg::CFG_W'(1024);
        end
        else if (cfg_wr_en)
        begin
            unique case (tals_pkg::cfg_idx_t'(cfg_index))
                tals_pkg::CFG_END_CODE:   cfg_reg.end_code        <= cfg_data;
                tals_pkg::CFG_BREAK_CODE: cfg_reg.line_break_code <= cfg_data;
                tals_pkg::CFG_TAG_CODE:   cfg_reg.tag_open_code   <= cfg_data;
                tals_pkg::CFG_LEN_LIMIT:  cfg_reg.length_limit    <= cfg_data;
                default:                  cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    tals_front #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .cfg      (cfg_reg),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op       (front_op)
    );

    tals_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_op     (queue_op)
    );

    tals_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (queue_valid),
        .op_ready (queue_ready),
        .op       (queue_op),
        .cfg      (cfg_reg),
        .result   (result)
    );

endmodule
